@@ src/binary_min_heap_priority_queue_top_defines.svh @@
// Assertion macros for the heap priority queue.
`ifndef BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMHPQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bmhpq_pkg.sv @@
// Shared types and constants for the heap priority queue.
package bmhpq_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int PRIO_W       = 16;
    localparam int DATA_W       = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 7;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
    } t_entry;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

@@ src/bmhpq_ram.sv @@
// Heap entry store: one write port, two registered read ports.
module bmhpq_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [ADDR_W-1:0]  i_waddr,
    input  bmhpq_pkg::t_entry  i_wdata,
    input  logic [ADDR_W-1:0]  i_raddr_a,
    input  logic [ADDR_W-1:0]  i_raddr_b,
    output bmhpq_pkg::t_entry  o_rdata_a,
    output bmhpq_pkg::t_entry  o_rdata_b
);
    import bmhpq_pkg::*;

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read-before-write on a same-address collision; the controller never relies on it
    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

@@ src/binary_min_heap_priority_queue_top.sv @@
// Binary min-heap priority queue: heap array in a synchronous RAM, sift controller.
//
// Each accepted transfer is an enqueue (opcode 0) or a dequeue of the minimum
// (opcode 1) and yields exactly one result transfer carrying the status, the
// removed entry on a good dequeue and the fill level after the operation.
// Entries live in a two-read, one-write RAM with registered reads; the
// entry being moved is held in a register so each heap level costs one read and
// one write, never a full swap. One item is worked on at a time, and the next
// item can be taken once the result has been loaded. An enqueue reads the
// parent and compares at each level it climbs, and writes the entry where it
// stops; a dequeue reads the root and the last entry, then at each level it
// sinks reads both children, compares and writes back; a full or empty
// rejection goes straight to the result. The result waits in an output
// register, so a stalled consumer only holds off the next input once the
// controller has finished the following item. Ties on the way down take the
// left child; entries of equal priority do not overtake their parent. No
// clearing pass is needed after reset: only slots below the count are ever read.
module binary_min_heap_priority_queue_top #(
    parameter int CAPACITY = bmhpq_pkg::DEF_CAPACITY
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_opcode,
    input  logic [bmhpq_pkg::PRIO_W-1:0]   i_priority_req,
    input  logic [bmhpq_pkg::DATA_W-1:0]   i_payload,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bmhpq_pkg::STATUS_W-1:0] o_status,
    output logic [bmhpq_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [bmhpq_pkg::DATA_W-1:0]   o_out_payload,
    output logic [bmhpq_pkg::COUNT_W-1:0]  o_count
);
    import bmhpq_pkg::*;

    `include "binary_min_heap_priority_queue_top_defines.svh"

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CIW = AW + 2;   // child index, can run past the array

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_UP_RD  = 8'b0000_0010,
        S_UP_CMP = 8'b0000_0100,
        S_DQ_RD  = 8'b0000_1000,
        S_DQ_GET = 8'b0001_0000,
        S_DN_RD  = 8'b0010_0000,
        S_DN_CMP = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_pos, n_pos;
    t_entry             r_move, n_move;       // entry being sifted
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [PRIO_W-1:0]  r_res_prio, n_res_prio;
    logic [DATA_W-1:0]  r_res_data, n_res_data;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [PRIO_W-1:0]   r_out_prio;
    logic [DATA_W-1:0]   r_out_data;
    logic [COUNT_W-1:0]  r_out_count;

    // RAM port signals
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    t_entry         w_wdata;
    logic [AW-1:0]  w_raddr_a, w_raddr_b;
    t_entry         w_rdata_a, w_rdata_b;

    logic           w_in_xfer;
    logic           w_out_load;
    logic [AW-1:0]  w_parent;
    logic [CIW-1:0] w_left, w_right, w_cnt_x;
    logic           w_left_ok, w_right_ok, w_take_right;
    t_entry         w_pick;
    logic [AW-1:0]  w_pick_addr;

    bmhpq_ram #(
        .DEPTH  (CAPACITY),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_load = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    // heap index arithmetic
    assign w_parent   = (r_pos - AW'(1)) >> 1;
    assign w_left     = CIW'({r_pos, 1'b1});
    assign w_right    = w_left + CIW'(1);
    assign w_cnt_x    = CIW'(r_count);
    assign w_left_ok  = (w_left < w_cnt_x);
    assign w_right_ok = (w_right < w_cnt_x);

    // smaller child, left wins a tie (read port a holds left, b holds right)
    assign w_take_right = w_right_ok && (w_rdata_a.prio > w_rdata_b.prio);
    assign w_pick       = w_take_right ? w_rdata_b : w_rdata_a;
    assign w_pick_addr  = w_take_right ? w_right[AW-1:0] : w_left[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_move       = r_move;
        n_res_status = r_res_status;
        n_res_prio   = r_res_prio;
        n_res_data   = r_res_data;
        w_we         = 1'b0;
        w_waddr      = r_pos;
        w_wdata      = r_move;
        w_raddr_a    = '0;
        w_raddr_b    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_res_status = ST_OK;
                    n_res_prio   = '0;
                    n_res_data   = '0;
                    if (i_opcode == OP_DEQ) begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_FIN;
                        end else begin
                            n_count = r_count - CW'(1);
                            n_state = S_DQ_RD;
                        end
                    end else begin
                        if (r_count == CW'(CAPACITY)) begin
                            n_res_status = ST_FULL;
                            n_state      = S_FIN;
                        end else begin
                            n_move.prio = i_priority_req;
                            n_move.data = i_payload;
                            n_pos       = r_count[AW-1:0];
                            n_count     = r_count + CW'(1);
                            n_state     = S_UP_RD;
                        end
                    end
                end
            end

            S_UP_RD: begin
                if (r_pos == '0) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_raddr_a = w_parent;
                    n_state   = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                w_we = 1'b1;
                if (r_move.prio < w_rdata_a.prio) begin
                    // parent moves down into the hole
                    w_wdata = w_rdata_a;
                    n_pos   = w_parent;
                    n_state = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_DQ_RD: begin
                // root and last entry; r_count already holds the new fill
                w_raddr_a = '0;
                w_raddr_b = r_count[AW-1:0];
                n_state   = S_DQ_GET;
            end

            S_DQ_GET: begin
                n_res_prio = w_rdata_a.prio;
                n_res_data = w_rdata_a.data;
                n_move     = w_rdata_b;
                n_pos      = '0;
                n_state    = (r_count == '0) ? S_FIN : S_DN_RD;
            end

            S_DN_RD: begin
                if (!w_left_ok) begin
                    w_we    = 1'b1;
                    n_state = S_FIN;
                end else begin
                    w_raddr_a = w_left[AW-1:0];
                    w_raddr_b = w_right_ok ? w_right[AW-1:0] : w_left[AW-1:0];
                    n_state   = S_DN_CMP;
                end
            end

            S_DN_CMP: begin
                w_we = 1'b1;
                if (w_pick.prio < r_move.prio) begin
                    // child moves up into the hole
                    w_wdata = w_pick;
                    n_pos   = w_pick_addr;
                    n_state = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_move       <= n_move;
        r_res_status <= n_res_status;
        r_res_prio   <= n_res_prio;
        r_res_data   <= n_res_data;
        if (w_out_load) begin
            r_out_status <= r_res_status;
            r_out_prio   <= r_res_prio;
            r_out_data   <= r_res_data;
            r_out_count  <= COUNT_W'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_priority = r_out_prio;
    assign o_out_payload  = r_out_data;
    assign o_count        = r_out_count;

    // the fill level grows by one on every accepted enqueue with room
    `BMHPQ_ASSERT_NEXT(a_enq_count,
        w_in_xfer && (i_opcode == OP_ENQ) && (r_count < CW'(CAPACITY)),
        r_count == $past(r_count) + CW'(1), "enqueue did not grow the heap")
    // a dequeue on an empty heap reports empty and leaves the heap alone
    `BMHPQ_ASSERT_NEXT(a_deq_empty, w_in_xfer && (i_opcode == OP_DEQ) && (r_count == '0),
        (r_res_status == ST_EMPTY) && (r_count == '0), "empty dequeue mishandled")
    // the sift never writes outside the live part of the heap
    `BMHPQ_ASSERT_NOW(a_wr_live, w_we, CW'(w_waddr) < r_count, "heap write beyond fill level")
    // a result appears only when the controller has finished an item
    `BMHPQ_ASSERT_NEXT(a_out_src, !r_out_valid && (r_state != S_FIN), !r_out_valid,
        "result without a finished item")

endmodule

@@ verif/tb_binary_min_heap_priority_queue_top.sv @@
// Self-checking testbench for the binary min-heap priority queue: heap predictor, driver, monitor.
module tb_binary_min_heap_priority_queue_top;
    import bmhpq_pkg::*;

    localparam int HEAP_CAP  = DEF_CAPACITY;
    localparam int DUE_DEPTH = 4096;   // ring of expected results, far deeper than the backlog
    localparam int RAND_OPS  = 1950;

    // One result transfer as the queue should return it.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PRIO_W-1:0]   prio;
        logic [DATA_W-1:0]   data;
        logic [COUNT_W-1:0]  count;
    } t_heap_res;

    // Entries of the pending list: a queue operation, a hold until the block is drained,
    // or a change of the idling pattern on both sides.
    typedef enum logic [1:0] {STEP_OP, STEP_DRAIN, STEP_PHASE} t_step_kind;

    typedef struct {
        t_step_kind        kind;
        logic              opcode;
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] data;
        int                idle_pct;
        int                stall_pct;
    } t_step;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_in_valid     = 1'b0;
    logic                o_in_stall;
    logic                i_opcode       = OP_ENQ;
    logic [PRIO_W-1:0]   i_priority_req = '0;
    logic [DATA_W-1:0]   i_payload      = '0;
    logic                o_out_valid;
    logic                i_out_stall    = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [PRIO_W-1:0]   o_out_priority;
    logic [DATA_W-1:0]   o_out_payload;
    logic [COUNT_W-1:0]  o_count;

    // Predictor state: its own copy of the heap and its fill level.
    logic [PRIO_W-1:0] heap_key [HEAP_CAP];
    logic [DATA_W-1:0] heap_val [HEAP_CAP];
    int                heap_fill = 0;

    t_step     step_q[$];                 // work still to be offered on the input channel
    t_heap_res due_res [DUE_DEPTH];       // predicted results, indexed by transfer number
    int        n_issued   = 0;            // input transfers so far (updated at the edge)
    int        n_returned = 0;            // result transfers checked so far
    int        n_err      = 0;
    int        send_idle  = 0;            // sender idle chance, per cent
    int        stall_pct  = 0;            // receiver stall chance, per cent

    binary_min_heap_priority_queue_top #(
        .CAPACITY(HEAP_CAP)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_priority_req (i_priority_req),
        .i_payload      (i_payload),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_out_priority (o_out_priority),
        .o_out_payload  (o_out_payload),
        .o_count        (o_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Heap predictor
    // ------------------------------------------------------------------
    function automatic void swap_heap_slots(int a, int b);
        logic [PRIO_W-1:0] k;
        logic [DATA_W-1:0] v;
        k = heap_key[a];
        v = heap_val[a];
        heap_key[a] = heap_key[b];
        heap_val[a] = heap_val[b];
        heap_key[b] = k;
        heap_val[b] = v;
    endfunction

    // Applies one operation to the predicted heap and returns what the block should report.
    function automatic t_heap_res apply_heap_op(logic op, logic [PRIO_W-1:0] prio,
                                                logic [DATA_W-1:0] data);
        t_heap_res r;
        int        pos;
        int        par;
        int        lft;
        int        pick;
        bit        moving;
        r        = '0;
        r.status = ST_OK;
        if (op == OP_ENQ) begin
            if (heap_fill >= HEAP_CAP) begin
                r.status = ST_FULL;                 // dropped, heap untouched
            end else begin
                pos           = heap_fill;
                heap_key[pos] = prio;
                heap_val[pos] = data;
                heap_fill++;
                // climb only while strictly smaller: equal keys stay below their parent
                moving = 1'b1;
                while (pos > 0 && moving) begin
                    par = (pos - 1) / 2;
                    if (heap_key[pos] < heap_key[par]) begin
                        swap_heap_slots(pos, par);
                        pos = par;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end else if (heap_fill == 0) begin
            r.status = ST_EMPTY;                    // payload fields stay zero
        end else begin
            r.prio = heap_key[0];
            r.data = heap_val[0];
            heap_fill--;
            heap_key[0] = heap_key[heap_fill];
            heap_val[0] = heap_val[heap_fill];
            // sink: smaller child, left on a tie, swap only while strictly smaller
            pos    = 0;
            moving = 1'b1;
            while (moving) begin
                lft = 2 * pos + 1;
                if (lft >= heap_fill) begin
                    moving = 1'b0;
                end else begin
                    pick = (lft + 1 < heap_fill && heap_key[lft] > heap_key[lft + 1]) ?
                           lft + 1 : lft;
                    if (heap_key[pick] < heap_key[pos]) begin
                        swap_heap_slots(pos, pick);
                        pos = pick;
                    end else begin
                        moving = 1'b0;
                    end
                end
            end
        end
        r.count = heap_fill[COUNT_W-1:0];
        return r;
    endfunction

    function automatic void compare_field(string name, logic [DATA_W-1:0] want,
                                          logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch on result %0d, expected %0h, got %0h",
                     $time, name, n_returned, want, got);
            n_err++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the pending list on the input channel.
    // A transfer is taken when valid is high and stall low at the edge; until
    // then valid and payload hold still.
    // Markers are dealt with only while valid is low.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drv
        logic took;
        took = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (took) begin
                // the slot at the old transfer number is never one the monitor reads now
                due_res[n_issued % DUE_DEPTH] = apply_heap_op(i_opcode, i_priority_req,
                                                              i_payload);
                n_issued <= n_issued + 1;
                void'(step_q.pop_front());
            end
            if (i_in_valid && !took) begin
                // stalled transfer: valid and payload stay as they are
            end else if (step_q.size() != 0 && step_q[0].kind == STEP_OP &&
                    $urandom_range(99) >= send_idle) begin
                i_in_valid     <= 1'b1;
                i_opcode       <= step_q[0].opcode;
                i_priority_req <= step_q[0].prio;
                i_payload      <= step_q[0].data;
            end else begin
                i_in_valid <= 1'b0;
                if (!took && step_q.size() != 0) begin
                    if (step_q[0].kind == STEP_PHASE) begin
                        send_idle = step_q[0].idle_pct;
                        stall_pct <= step_q[0].stall_pct;
                        void'(step_q.pop_front());
                    end else if (step_q[0].kind == STEP_DRAIN && n_issued == n_returned) begin
                        // sender held back until every outstanding result is home
                        void'(step_q.pop_front());
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transfer against the oldest prediction and
    // throws random stall on the result channel.
    // n_issued is read before this edge's update, so a transfer taken at the
    // same edge can never be matched against a result already on the port.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (n_returned >= n_issued) begin
                    $display("%0t: unexpected result, expected none, got status %0h prio %0h "
                             , $time, o_status, o_out_priority,
                             "payload %0h count %0d", o_out_payload, o_count);
                    n_err++;
                end else begin
                    compare_field("status",  due_res[n_returned % DUE_DEPTH].status, o_status);
                    compare_field("priority", due_res[n_returned % DUE_DEPTH].prio,
                                  o_out_priority);
                    compare_field("payload", due_res[n_returned % DUE_DEPTH].data,
                                  o_out_payload);
                    compare_field("count",   due_res[n_returned % DUE_DEPTH].count, o_count);
                    n_returned <= n_returned + 1;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_op(logic op, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] data);
        t_step s;
        s.kind      = STEP_OP;
        s.opcode    = op;
        s.prio      = prio;
        s.data      = data;
        s.idle_pct  = 0;
        s.stall_pct = 0;
        step_q.push_back(s);
    endtask

    task automatic push_marker(t_step_kind kind, int idle_pct, int stall);
        t_step s;
        s.kind      = kind;
        s.opcode    = OP_ENQ;
        s.prio      = '0;
        s.data      = '0;
        s.idle_pct  = idle_pct;
        s.stall_pct = stall;
        step_q.push_back(s);
    endtask

    // Mix of narrow keys (plenty of ties), the two extremes and the full range.
    function automatic logic [PRIO_W-1:0] pick_prio();
        case ($urandom_range(3))
            0:       return PRIO_W'($urandom_range(15));
            1:       return $urandom_range(1) ? '1 : '0;
            default: return PRIO_W'($urandom);
        endcase
    endfunction

    initial begin : stim
        int idle_tab [4];
        int stall_tab[4];
        int left;
        int seg;
        int enq_pct;
        idle_tab  = '{0, 45, 0, 15};
        stall_tab = '{0, 0, 45, 15};

        // Directed opening: empty dequeue with junk in the ignored fields, key
        // extremes, a run of equal keys, then drain past empty again.
        push_marker(STEP_PHASE, 0, 0);
        push_op(OP_DEQ, '1, '1);
        push_op(OP_ENQ, '1, '0);
        push_op(OP_ENQ, '0, '1);
        push_op(OP_ENQ, 16'd8, 32'h0000_000a);
        push_op(OP_ENQ, 16'd8, 32'h0000_000b);
        push_op(OP_ENQ, 16'd8, 32'h0000_000c);
        push_op(OP_ENQ, 16'd8, 32'h0000_000d);
        push_op(OP_ENQ, 16'd3, 32'h5a5a_a5a5);
        push_op(OP_ENQ, '1, 32'hffff_0000);
        push_op(OP_DEQ, 16'h5555, 32'haaaa_aaaa);
        push_op(OP_ENQ, 16'd8, 32'h0000_000e);
        repeat (9) push_op(OP_DEQ, PRIO_W'($urandom), $urandom);
        push_op(OP_DEQ, '0, '0);
        push_marker(STEP_DRAIN, 0, 0);

        // Random part: four idling phases, each in segments that lean towards
        // filling (to reach the full heap), emptying, or an even mix.
        for (int ph = 0; ph < 4; ph++) begin
            push_marker(STEP_PHASE, idle_tab[ph], stall_tab[ph]);
            left = RAND_OPS / 4;
            while (left > 0) begin
                seg = $urandom_range(20, 140);
                if (seg > left) seg = left;
                case ($urandom_range(2))
                    0:       enq_pct = 85;
                    1:       enq_pct = 20;
                    default: enq_pct = 50;
                endcase
                repeat (seg) begin
                    if ($urandom_range(99) < enq_pct)
                        push_op(OP_ENQ, pick_prio(), $urandom);
                    else
                        push_op(OP_DEQ, PRIO_W'($urandom), $urandom);
                end
                left -= seg;
                if ($urandom_range(7) == 0) push_marker(STEP_DRAIN, 0, 0);
            end
            push_marker(STEP_DRAIN, 0, 0);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (step_q.size() != 0) @(posedge i_clk);
        while (n_returned != n_issued) @(posedge i_clk);
        // worst single operation is well under this; a late stray result gets caught here
        repeat (40) @(posedge i_clk);

        if (n_err == 0 && n_returned == n_issued) begin
            $display("tb_binary_min_heap_priority_queue_top passed");
        end else begin
            $display("tb_binary_min_heap_priority_queue_top failed");
        end
        $finish;
    end

    // Watchdog: the slowest plausible run is well below a tenth of this.
    initial begin
        #4000000;
        $display("tb_binary_min_heap_priority_queue_top failed");
        $finish;
    end

endmodule
